### rtl/rcpsd_pkg.sv
// Package for the RC pulse switch debouncer.
// Holds the event codes, the register map and the widths shared by the top level and its checker.
// No dependencies.
package rcpsd_pkg;

  // Field widths
  localparam int unsigned WIDTH_W = 16;
  localparam int unsigned HOLD_W  = 8;
  localparam int unsigned EVENT_W = 2;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // Switch event codes
  typedef logic [EVENT_W-1:0] sw_event_t;
  localparam sw_event_t EV_NONE = 2'd0;
  localparam sw_event_t EV_RISE = 2'd1;
  localparam sw_event_t EV_FALL = 2'd2;

  // Register indexes (byte address is 4 * index)
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_BAND_LOW  = 2'd0;
  localparam reg_idx_t REG_BAND_HIGH = 2'd1;
  localparam reg_idx_t REG_THRESHOLD = 2'd2;
  localparam reg_idx_t REG_HOLD      = 2'd3;

  // Register reset values
  localparam logic [WIDTH_W-1:0] BAND_LOW_RST  = 16'd0;
  localparam logic [WIDTH_W-1:0] BAND_HIGH_RST = 16'd65535;
  localparam logic [WIDTH_W-1:0] THRESHOLD_RST = 16'd1500;
  localparam logic [HOLD_W-1:0]  HOLD_RST      = 8'd1;

endpackage

### rtl/rc_pulse_switch_debouncer_top.sv
// Top level of the RC pulse switch debouncer.
// Holds the input register, the debounce logic, the result register and the register port.
// Depends on rcpsd_pkg.

// Debounces a two-position switch carried on a radio-control pulse channel.
// Each input beat is one frame (edge-seen flag and pulse width in us). Each
// frame gives exactly one result beat with a switch event: none, rise or fall.
// A frame is latched in an input register. When the result register can take it,
// one pass of compare and counter logic updates the debounce state and loads the
// result register. A new frame may be accepted every cycle while the result side
// does not stall, and the rate is then one frame per cycle. The user must write
// registers over the APB port only while no frame is in flight; the block itself
// does not enforce this.
module rc_pulse_switch_debouncer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_edge_present,
  input  logic [rcpsd_pkg::WIDTH_W-1:0] in_pulse_width,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rcpsd_pkg::EVENT_W-1:0] out_switch_event,
  // Register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcpsd_pkg::ADDR_W-1:0]  paddr,
  input  logic [rcpsd_pkg::DATA_W-1:0]  pwdata,
  output logic [rcpsd_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  // Configuration registers
  logic [rcpsd_pkg::WIDTH_W-1:0] band_low_r;
  logic [rcpsd_pkg::WIDTH_W-1:0] band_high_r;
  logic [rcpsd_pkg::WIDTH_W-1:0] threshold_r;
  logic [rcpsd_pkg::HOLD_W-1:0]  hold_r;

  // Input stage
  logic                          s1_valid_r;
  logic                          s1_edge_r;
  logic [rcpsd_pkg::WIDTH_W-1:0] s1_width_r;

  // Debounce state
  logic                          accepted_high_r, accepted_high_nxt;
  logic                          candidate_r, candidate_nxt;
  logic [rcpsd_pkg::HOLD_W-1:0]  run_count_r, run_count_nxt;
  logic                          seeded_r, seeded_nxt;

  // Result stage
  logic                          out_valid_r;
  rcpsd_pkg::sw_event_t          out_event_r, event_nxt;

  logic                          s2_ready;
  logic                          s1_advance;
  logic                          in_take;
  logic                          cfg_write;
  rcpsd_pkg::reg_idx_t           reg_idx;

  logic                          reading_ok;
  logic                          level;
  logic [rcpsd_pkg::HOLD_W-1:0]  need;

  // Handshake
  assign s2_ready   = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && s2_ready;
  assign in_stall   = s1_valid_r && !s2_ready;
  assign in_take    = in_valid && !in_stall;

  assign out_valid        = out_valid_r;
  assign out_switch_event = out_event_r;

  // Register port decode
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      rcpsd_pkg::REG_BAND_LOW:  prdata = {16'd0, band_low_r};
      rcpsd_pkg::REG_BAND_HIGH: prdata = {16'd0, band_high_r};
      rcpsd_pkg::REG_THRESHOLD: prdata = {16'd0, threshold_r};
      rcpsd_pkg::REG_HOLD:      prdata = {24'd0, hold_r};
      default:                  prdata = '0;
    endcase
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r  <= rcpsd_pkg::BAND_LOW_RST;
      band_high_r <= rcpsd_pkg::BAND_HIGH_RST;
      threshold_r <= rcpsd_pkg::THRESHOLD_RST;
      hold_r      <= rcpsd_pkg::HOLD_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        rcpsd_pkg::REG_BAND_LOW:  band_low_r  <= pwdata[15:0];
        rcpsd_pkg::REG_BAND_HIGH: band_high_r <= pwdata[15:0];
        rcpsd_pkg::REG_THRESHOLD: threshold_r <= pwdata[15:0];
        rcpsd_pkg::REG_HOLD:      hold_r      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Latch the incoming frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_edge_r  <= in_edge_present;
      s1_width_r <= in_pulse_width;
    end
  end

  // Debounce pass: band check, level, run counter and event
  always_comb begin
    reading_ok = s1_edge_r && (s1_width_r >= band_low_r) && (s1_width_r <= band_high_r);
    level      = s1_width_r >= threshold_r;
    need       = (hold_r == '0) ? {{(rcpsd_pkg::HOLD_W-1){1'b0}}, 1'b1} : hold_r;

    accepted_high_nxt = accepted_high_r;
    candidate_nxt     = candidate_r;
    run_count_nxt     = run_count_r;
    seeded_nxt        = seeded_r;
    event_nxt         = rcpsd_pkg::EV_NONE;

    if (!reading_ok) begin
      // No reading: fall back to the accepted level
      candidate_nxt = accepted_high_r;
      run_count_nxt = '0;
    end else begin
      if (level != candidate_r) begin
        candidate_nxt = level;
        run_count_nxt = {{(rcpsd_pkg::HOLD_W-1){1'b0}}, 1'b1};
      end else if (run_count_r < need) begin
        run_count_nxt = run_count_r + 1'b1;
      end

      if (run_count_nxt >= need) begin
        if (!seeded_r) begin
          // First stable level only seeds the baseline
          seeded_nxt        = 1'b1;
          accepted_high_nxt = level;
        end else if (level != accepted_high_r) begin
          accepted_high_nxt = level;
          event_nxt         = level ? rcpsd_pkg::EV_RISE : rcpsd_pkg::EV_FALL;
        end
      end
    end
  end

  // Advance state as the frame moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_high_r <= 1'b0;
      candidate_r     <= 1'b0;
      run_count_r     <= '0;
      seeded_r        <= 1'b0;
    end else if (s1_advance) begin
      accepted_high_r <= accepted_high_nxt;
      candidate_r     <= candidate_nxt;
      run_count_r     <= run_count_nxt;
      seeded_r        <= seeded_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_event_r <= event_nxt;
    end
  end

endmodule

### rtl/rcpsd_checker.sv
// Port-level checker for the RC pulse switch debouncer.
// Watches the top level's ports only; bound to rc_pulse_switch_debouncer_top.
// Depends on rcpsd_pkg.
module rcpsd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rcpsd_pkg::EVENT_W-1:0] out_switch_event
);

  logic                 out_beat;
  rcpsd_pkg::sw_event_t last_ev_r;

  assign out_beat = out_valid && !out_stall;

  // Track the last non-empty event delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ev_r <= rcpsd_pkg::EV_NONE;
    end else if (out_beat && (out_switch_event != rcpsd_pkg::EV_NONE)) begin
      last_ev_r <= out_switch_event;
    end
  end

  // Only the three defined event codes leave the block
  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_switch_event == rcpsd_pkg::EV_NONE ||
                   out_switch_event == rcpsd_pkg::EV_RISE ||
                   out_switch_event == rcpsd_pkg::EV_FALL))
    else $error("undefined switch event code");

  // Rises and falls alternate
  a_alternate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_switch_event != rcpsd_pkg::EV_NONE &&
     last_ev_r != rcpsd_pkg::EV_NONE) |-> (out_switch_event != last_ev_r))
    else $error("two switch events of the same direction in a row");

  // Input stalls only when a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_switch_event)))
    else $error("stalled result beat changed");

endmodule

bind rc_pulse_switch_debouncer_top rcpsd_checker u_rcpsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_switch_event (out_switch_event)
);
